// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- hdl/mppe_pkg.sv -----
`timescale 1ns / 1ps

package mppe_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_VARINT   = 3'd1,
        PH_TOPIC_HI = 3'd2,
        PH_TOPIC_LO = 3'd3,
        PH_TOPIC    = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_SKIP     = 3'd6,
        PH_DISCARD  = 3'd7
    } phase_t;

    localparam logic [1:0] ST_BYTE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    localparam int RL_W    = 28;
    localparam int TOPIC_W = 16;
    localparam int M_DATA_W = 32;

    typedef struct packed {
        logic       valid;
        logic [7:0] cmd_byte;
        logic [7:0] byte_offset;
        logic       cmd_last;
        logic [7:0] cmd_length;
        logic [2:0] ring_slot;
        logic [1:0] status;
    } result_t;

endpackage

// ----- hdl/mppe_parser.sv -----
`timescale 1ns / 1ps

module mppe_parser #(
    parameter int CMD_SLOTS      = 8,
    parameter int CMD_SLOT_BYTES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [7:0]         rx_byte,
    input  logic               buffer_start,
    output mppe_pkg::result_t  result
);

    localparam int SLOT_W = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;
    localparam int CNT_W  = $clog2(CMD_SLOT_BYTES);
    localparam int SLOT_CAP = CMD_SLOT_BYTES - 3;
    localparam int RL_W = mppe_pkg::RL_W;
    localparam int TW   = mppe_pkg::TOPIC_W;

    mppe_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [RL_W-1:0]  rl_reg, rl_next;
    logic [1:0]       vcnt_reg, vcnt_next;
    logic [TW-1:0]    tl_reg, tl_next;
    logic [RL_W-1:0]  bl_reg, bl_next;
    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [RL_W-1:0]  shifted;
    logic [RL_W-1:0]  rl_acc;
    logic             cont;
    logic             vlast;
    logic             rl_small;
    logic [TW-1:0]    topic_full;
    logic [RL_W:0]    topic_diff;
    logic             topic_over;
    logic             topic_rest_zero;
    logic [TW-1:0]    tl_dec;
    logic [RL_W-1:0]  bl_dec;
    logic             below_cap;
    logic [CNT_W-1:0] pc_inc;
    logic [SLOT_W-1:0] slot_adv;

    assign phase_eff = buffer_start ? mppe_pkg::PH_HEADER : phase_reg;
    assign cont      = rx_byte[7];
    assign vlast     = (vcnt_reg == 2'd3);

    always_comb begin
        case (vcnt_reg)
            2'd0:    shifted = {21'd0, rx_byte[6:0]};
            2'd1:    shifted = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    shifted = {7'd0, rx_byte[6:0], 14'd0};
            default: shifted = {rx_byte[6:0], 21'd0};
        endcase
    end

    assign rl_acc          = rl_reg | shifted;
    assign rl_small        = (rl_acc[RL_W-1:1] == '0);
    assign topic_full      = {tl_reg[TW-1:8], rx_byte};
    assign topic_diff      = {1'b0, bl_reg} - {{(RL_W+1-TW){1'b0}}, topic_full};
    assign topic_over      = topic_diff[RL_W];
    assign topic_rest_zero = (topic_diff[RL_W-1:0] == '0);
    assign tl_dec          = (tl_reg != '0) ? TW'(tl_reg - 1'b1) : '0;
    assign bl_dec          = (bl_reg != '0) ? RL_W'(bl_reg - 1'b1) : '0;
    assign below_cap       = (pc_reg < CNT_W'(SLOT_CAP));
    assign pc_inc          = CNT_W'(pc_reg + 1'b1);
    assign slot_adv        = (slot_reg == SLOT_W'(CMD_SLOTS - 1)) ? '0
                                                                  : SLOT_W'(slot_reg + 1'b1);

    always_comb begin
        phase_next = phase_eff;
        unique case (phase_eff)
            mppe_pkg::PH_HEADER: begin
                phase_next = mppe_pkg::PH_VARINT;
            end
            mppe_pkg::PH_VARINT: begin
                if (cont) begin
                    phase_next = vlast ? mppe_pkg::PH_DISCARD : mppe_pkg::PH_VARINT;
                end else if (rl_small) begin
                    phase_next = (rl_acc != '0) ? mppe_pkg::PH_SKIP : mppe_pkg::PH_HEADER;
                end else begin
                    phase_next = mppe_pkg::PH_TOPIC_HI;
                end
            end
            mppe_pkg::PH_TOPIC_HI: begin
                phase_next = mppe_pkg::PH_TOPIC_LO;
            end
            mppe_pkg::PH_TOPIC_LO: begin
                if (topic_over) begin
                    phase_next = (bl_reg != '0) ? mppe_pkg::PH_SKIP : mppe_pkg::PH_HEADER;
                end else if (topic_full != '0) begin
                    phase_next = mppe_pkg::PH_TOPIC;
                end else begin
                    phase_next = topic_rest_zero ? mppe_pkg::PH_HEADER
                                                 : mppe_pkg::PH_PAYLOAD;
                end
            end
            mppe_pkg::PH_TOPIC: begin
                if (tl_dec != '0) begin
                    phase_next = mppe_pkg::PH_TOPIC;
                end else begin
                    phase_next = (bl_reg == '0) ? mppe_pkg::PH_HEADER
                                                : mppe_pkg::PH_PAYLOAD;
                end
            end
            mppe_pkg::PH_PAYLOAD: begin
                phase_next = (bl_dec == '0) ? mppe_pkg::PH_HEADER : mppe_pkg::PH_PAYLOAD;
            end
            mppe_pkg::PH_SKIP: begin
                phase_next = (bl_dec == '0) ? mppe_pkg::PH_HEADER : mppe_pkg::PH_SKIP;
            end
            mppe_pkg::PH_DISCARD: begin
                phase_next = mppe_pkg::PH_DISCARD;
            end
        endcase
    end

    always_comb begin
        rl_next   = rl_reg;
        vcnt_next = vcnt_reg;
        tl_next   = tl_reg;
        bl_next   = bl_reg;
        pc_next   = pc_reg;
        slot_next = slot_reg;
        result    = '0;
        result.ring_slot = 3'(slot_reg);
        unique case (phase_eff)
            mppe_pkg::PH_HEADER: begin
                rl_next   = '0;
                vcnt_next = '0;
            end
            mppe_pkg::PH_VARINT: begin
                rl_next   = rl_acc;
                vcnt_next = vcnt_reg + 2'd1;
                if (cont) begin
                    if (vlast) begin
                        result.valid    = 1'b1;
                        result.cmd_last = 1'b1;
                        result.status   = mppe_pkg::ST_MALFORMED;
                    end
                end else if (rl_small) begin
                    bl_next         = rl_acc;
                    result.valid    = 1'b1;
                    result.cmd_last = 1'b1;
                    result.status   = mppe_pkg::ST_MALFORMED;
                end else begin
                    bl_next = RL_W'(rl_acc - 2'd2);
                end
            end
            mppe_pkg::PH_TOPIC_HI: begin
                tl_next = {rx_byte, 8'd0};
            end
            mppe_pkg::PH_TOPIC_LO: begin
                tl_next = topic_full;
                pc_next = '0;
                if (topic_over) begin
                    result.valid    = 1'b1;
                    result.cmd_last = 1'b1;
                    result.status   = mppe_pkg::ST_MALFORMED;
                end else begin
                    bl_next = topic_diff[RL_W-1:0];
                    if (topic_full == '0 && topic_rest_zero) begin
                        result.valid    = 1'b1;
                        result.cmd_last = 1'b1;
                        result.status   = mppe_pkg::ST_EMPTY;
                        slot_next       = slot_adv;
                    end
                end
            end
            mppe_pkg::PH_TOPIC: begin
                tl_next = tl_dec;
                if (tl_dec == '0 && bl_reg == '0) begin
                    result.valid    = 1'b1;
                    result.cmd_last = 1'b1;
                    result.status   = mppe_pkg::ST_EMPTY;
                    slot_next       = slot_adv;
                end
            end
            mppe_pkg::PH_PAYLOAD: begin
                bl_next = bl_dec;
                if (below_cap) begin
                    pc_next            = pc_inc;
                    result.valid       = 1'b1;
                    result.cmd_byte    = rx_byte;
                    result.byte_offset = 8'(pc_reg);
                    result.status      = mppe_pkg::ST_BYTE;
                    if (bl_dec == '0) begin
                        result.cmd_last   = 1'b1;
                        result.cmd_length = 8'(pc_inc);
                        slot_next         = slot_adv;
                    end
                end else if (bl_dec == '0) begin
                    result.valid      = 1'b1;
                    result.cmd_last   = 1'b1;
                    result.cmd_length = 8'(pc_reg);
                    result.status     = mppe_pkg::ST_TRUNC;
                    slot_next         = slot_adv;
                end
            end
            mppe_pkg::PH_SKIP: begin
                bl_next = bl_dec;
            end
            mppe_pkg::PH_DISCARD: begin
                rl_next = rl_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mppe_pkg::PH_HEADER;
            rl_reg    <= '0;
            vcnt_reg  <= '0;
            tl_reg    <= '0;
            bl_reg    <= '0;
            pc_reg    <= '0;
            slot_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            rl_reg    <= rl_next;
            vcnt_reg  <= vcnt_next;
            tl_reg    <= tl_next;
            bl_reg    <= bl_next;
            pc_reg    <= pc_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// ----- hdl/mqtt_publish_payload_extractor_core.sv -----
`timescale 1ns / 1ps

// Extracts the payload of QoS-0 PUBLISH packets from a received byte stream.
// The input channel carries one stream byte per request in s_tdata, with
// s_tuser set on the first byte of a received buffer, which realigns the
// parser to a fixed-header byte and drops any packet in progress.
// The output channel carries at most one request per input byte: a payload
// byte with its offset, an empty-command mark, a malformed-packet mark or a
// truncation mark. m_tlast is set on the final request of a packet, and
// m_tuser gives the status code.
// A byte is captured in the input register, and its request is then
// registered in the output register.
// One byte is accepted every cycle while the output is not stalled; the
// parse step is a single pass of logic between the two registers.
// Reset returns the parser to waiting for a header byte, empties both
// registers and sets the command ring slot to zero.
// While m_tvalid is high and m_tready low, the output register holds and the
// input register stops advancing, so s_tready drops once it is full.
module mqtt_publish_payload_extractor_core #(
    parameter int CMD_SLOTS      = 8,
    parameter int CMD_SLOT_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // buffer_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cmd_byte, byte_offset, cmd_length, ring_slot, zero pad
    output logic        m_tlast,   // cmd_last
    output logic [1:0]  m_tuser    // status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       stage_adv;
    logic       step_en;

    mppe_pkg::result_t res;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic        out_last_reg;
    logic [1:0]  out_user_reg;

    assign stage_adv = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || stage_adv;
    assign step_en   = in_valid_reg && stage_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    mppe_parser #(
        .CMD_SLOTS      (CMD_SLOTS),
        .CMD_SLOT_BYTES (CMD_SLOT_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .rx_byte      (in_byte_reg),
        .buffer_start (in_start_reg),
        .result       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (stage_adv) begin
            out_valid_next = step_en && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res.valid) begin
            out_data_reg <= {5'd0, res.ring_slot, res.cmd_length, res.byte_offset,
                             res.cmd_byte};
            out_last_reg <= res.cmd_last;
            out_user_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- hdl/mppe_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mppe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    `ASSERT_CLK(a_mid_is_byte, aclk, aresetn, m_tvalid && !m_tlast |-> m_tuser == mppe_pkg::ST_BYTE && m_tdata[23:16] == 8'd0)

    `ASSERT_CLK(a_mark_no_byte, aclk, aresetn, m_tvalid && m_tuser != mppe_pkg::ST_BYTE |-> m_tlast && m_tdata[15:0] == 16'd0)

    `ASSERT_CLK(a_empty_len_zero, aclk, aresetn, m_tvalid && (m_tuser == mppe_pkg::ST_EMPTY || m_tuser == mppe_pkg::ST_MALFORMED) |-> m_tdata[23:16] == 8'd0)

endmodule

bind mqtt_publish_payload_extractor_core mppe_checker u_mppe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int CMD_SLOTS      = 8;
    localparam int CMD_SLOT_BYTES = 256;
    localparam int SLOT_CAP       = CMD_SLOT_BYTES - 3;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [7:0] byte_offset;
        logic       cmd_last;
        logic [7:0] cmd_length;
        logic [2:0] ring_slot;
        logic [1:0] status;
    } cmd_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // rx_byte
    logic        s_tuser  = 1'b0;    // buffer_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // cmd_byte, byte_offset, cmd_length, ring_slot, zero pad
    logic        m_tlast;            // cmd_last
    logic [1:0]  m_tuser;            // status

    mqtt_publish_payload_extractor_core #(
        .CMD_SLOTS(CMD_SLOTS),
        .CMD_SLOT_BYTES(CMD_SLOT_BYTES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    // Parser state tracked alongside the block.
    mppe_pkg::phase_t rx_phase = mppe_pkg::PH_HEADER;
    logic [27:0] rem_len      = '0;
    logic [2:0]  varint_count = '0;
    logic [15:0] topic_left   = '0;
    logic [27:0] body_left    = '0;
    logic [7:0]  stored_count = '0;
    logic [2:0]  ring_slot    = '0;

    cmd_result_t predicted_cmds[$];

    int cycle_count    = 0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int packets_sent   = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int sender_idle_pct   = 38;
    int receiver_stall_pct = 70;
    bit need_realign   = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic void push_cmd(input logic [7:0] data, input logic [7:0] offset,
                                     input logic last, input logic [7:0] length,
                                     input logic [1:0] status);
        cmd_result_t r;
        r.cmd_byte    = data;
        r.byte_offset = offset;
        r.cmd_last    = last;
        r.cmd_length  = length;
        r.ring_slot   = ring_slot;
        r.status      = status;
        predicted_cmds.push_back(r);
    endfunction

    function automatic void close_command();
        ring_slot = (ring_slot == 3'(CMD_SLOTS - 1)) ? 3'd0 : ring_slot + 3'd1;
        rx_phase  = mppe_pkg::PH_HEADER;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b, input logic start);
        logic [7:0] off;
        if (start) begin
            rx_phase = mppe_pkg::PH_HEADER;
        end
        case (rx_phase)
            mppe_pkg::PH_HEADER: begin
                rem_len      = '0;
                varint_count = '0;
                rx_phase     = mppe_pkg::PH_VARINT;
            end
            mppe_pkg::PH_VARINT: begin
                rem_len = rem_len | (28'(b[6:0]) << (7 * varint_count[1:0]));
                varint_count = varint_count + 3'd1;
                if (b[7]) begin
                    if (varint_count >= 3'd4) begin
                        rx_phase = mppe_pkg::PH_DISCARD;
                        push_cmd(8'd0, 8'd0, 1'b1, 8'd0, mppe_pkg::ST_MALFORMED);
                    end
                end else if (rem_len < 28'd2) begin
                    body_left = rem_len;
                    if (body_left != 0) begin
                        rx_phase = mppe_pkg::PH_SKIP;
                    end else begin
                        rx_phase = mppe_pkg::PH_HEADER;
                    end
                    push_cmd(8'd0, 8'd0, 1'b1, 8'd0, mppe_pkg::ST_MALFORMED);
                end else begin
                    body_left = rem_len - 28'd2;
                    rx_phase  = mppe_pkg::PH_TOPIC_HI;
                end
            end
            mppe_pkg::PH_TOPIC_HI: begin
                topic_left = {b, 8'h00};
                rx_phase   = mppe_pkg::PH_TOPIC_LO;
            end
            mppe_pkg::PH_TOPIC_LO: begin
                topic_left[7:0] = b;
                stored_count    = '0;
                if (28'(topic_left) > body_left) begin
                    if (body_left != 0) begin
                        rx_phase = mppe_pkg::PH_SKIP;
                    end else begin
                        rx_phase = mppe_pkg::PH_HEADER;
                    end
                    push_cmd(8'd0, 8'd0, 1'b1, 8'd0, mppe_pkg::ST_MALFORMED);
                end else begin
                    body_left = body_left - 28'(topic_left);
                    if (topic_left != 0) begin
                        rx_phase = mppe_pkg::PH_TOPIC;
                    end else if (body_left == 0) begin
                        push_cmd(8'd0, 8'd0, 1'b1, 8'd0, mppe_pkg::ST_EMPTY);
                        close_command();
                    end else begin
                        rx_phase = mppe_pkg::PH_PAYLOAD;
                    end
                end
            end
            mppe_pkg::PH_TOPIC: begin
                if (topic_left != 0) begin
                    topic_left = topic_left - 16'd1;
                end
                if (topic_left == 0) begin
                    if (body_left == 0) begin
                        push_cmd(8'd0, 8'd0, 1'b1, 8'd0, mppe_pkg::ST_EMPTY);
                        close_command();
                    end else begin
                        rx_phase = mppe_pkg::PH_PAYLOAD;
                    end
                end
            end
            mppe_pkg::PH_PAYLOAD: begin
                if (body_left != 0) begin
                    body_left = body_left - 28'd1;
                end
                if (stored_count < SLOT_CAP) begin
                    off = stored_count;
                    stored_count = stored_count + 8'd1;
                    if (body_left == 0) begin
                        push_cmd(b, off, 1'b1, stored_count, mppe_pkg::ST_BYTE);
                        close_command();
                    end else begin
                        push_cmd(b, off, 1'b0, 8'd0, mppe_pkg::ST_BYTE);
                    end
                end else if (body_left == 0) begin
                    push_cmd(8'd0, 8'd0, 1'b1, stored_count, mppe_pkg::ST_TRUNC);
                    close_command();
                end
            end
            mppe_pkg::PH_SKIP: begin
                if (body_left != 0) begin
                    body_left = body_left - 28'd1;
                end
                if (body_left == 0) begin
                    rx_phase = mppe_pkg::PH_HEADER;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Results are checked before the byte accepted at the same edge is parsed,
    // since any result at that edge belongs to an earlier byte.
    always @(posedge aclk) begin : check_and_predict
        cmd_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                status_seen[m_tuser]++;
                if (predicted_cmds.size() == 0) begin
                    report_error($sformatf("unexpected request, status %0d", m_tuser));
                end else begin
                    want = predicted_cmds.pop_front();
                    check_field("cmd_byte", m_tdata[7:0], want.cmd_byte);
                    check_field("byte_offset", m_tdata[15:8], want.byte_offset);
                    check_field("cmd_length", m_tdata[23:16], want.cmd_length);
                    check_field("ring_slot", m_tdata[26:24], want.ring_slot);
                    check_field("pad", m_tdata[31:27], 0);
                    check_field("cmd_last", m_tlast, want.cmd_last);
                    check_field("status", m_tuser, want.status);
                end
            end
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata, s_tuser);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Header, remaining length in nb varint bytes, then rem body bytes whose
    // first two carry the topic length; cut >= 0 stops after that many bytes.
    task automatic send_publish(input int unsigned rem, input int nb, input logic [15:0] topic,
                                input logic realign, input int cut);
        int total;
        logic [7:0] b;
        total = 1 + nb + int'(rem);
        if (cut >= 0 && cut < total) begin
            total = cut;
        end
        packets_sent++;
        for (int i = 0; i < total; i++) begin
            if (i == 0) begin
                b = 8'($urandom);
            end else if (i <= nb) begin
                b[6:0] = 7'(rem >> (7 * (i - 1)));
                b[7]   = (i < nb);
            end else if (i == nb + 1) begin
                b = topic[15:8];
            end else if (i == nb + 2) begin
                b = topic[7:0];
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, realign && (i == 0));
        end
    endtask

    task automatic send_long_varint(input logic realign, input int junk);
        send_byte(8'($urandom), realign);
        repeat (4) send_byte(8'($urandom) | 8'h80, 1'b0);
        repeat (junk) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (predicted_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    task automatic test_basic_payloads();
        send_publish(2 + 3 + 4, 1, 16'd3, 1'b1, -1);
        send_publish(2 + 0 + 2, 1, 16'd0, 1'b0, -1);
        send_publish(2 + 1 + 1, 4, 16'd1, 1'b0, -1);
    endtask

    task automatic test_empty_commands();
        send_publish(2, 1, 16'd0, 1'b0, -1);
        send_publish(2 + 5, 2, 16'd5, 1'b0, -1);
    endtask

    task automatic test_malformed_packets();
        send_publish(0, 1, 16'd0, 1'b0, -1);
        send_publish(1, 1, 16'd0, 1'b0, -1);
        send_publish(4, 1, 16'd5, 1'b0, -1);
        send_publish(2, 1, 16'hFFFF, 1'b0, -1);
        send_long_varint(1'b0, 3);
        send_publish(2 + 1 + 1, 1, 16'd1, 1'b1, -1);
    endtask

    task automatic test_buffer_realign();
        send_publish(28'h0FFFFFFF, 4, 16'hFFFF, 1'b0, 1 + 4 + 2 + 3);
        send_publish(2 + 2 + 6, 1, 16'd2, 1'b1, 1 + 1 + 2 + 2 + 2);
        send_publish(300, 2, 16'd0, 1'b1, 2);
        send_publish(2 + 1 + 3, 1, 16'd1, 1'b1, -1);
    endtask

    task automatic test_slot_overflow();
        send_publish(2 + 1 + SLOT_CAP, 2, 16'd1, 1'b0, -1);
        send_publish(2 + 1 + SLOT_CAP + 1, 2, 16'd1, 1'b0, -1);
        send_publish(2 + 0 + 260, 3, 16'd0, 1'b0, -1);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        int topic;
        int payload;
        int rem;
        int nb;
        int min_nb;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                topic = $urandom_range(0, 6);
                if ($urandom_range(0, 199) == 0) begin
                    payload = $urandom_range(250, 258);
                end else if ($urandom_range(0, 9) == 0) begin
                    payload = $urandom_range(13, 60);
                end else begin
                    payload = $urandom_range(0, 12);
                end
                rem = 2 + topic + payload;
                min_nb = (rem > 127) ? 2 : 1;
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(min_nb, 4) : min_nb;
                if (pick < 70) begin
                    send_publish(rem, nb, 16'(topic),
                                 need_realign || ($urandom_range(0, 3) == 0), -1);
                    need_realign = 1'b0;
                end else begin
                    send_publish(rem, nb, 16'(topic), 1'b1,
                                 $urandom_range(1, nb + rem));
                    need_realign = 1'b1;
                end
            end else if (pick < 86) begin
                send_publish($urandom_range(0, 1), 1, 16'd0, need_realign, -1);
                need_realign = 1'b0;
            end else if (pick < 91) begin
                rem = $urandom_range(2, 12);
                send_publish(rem, 1, 16'($urandom_range(rem - 1, 65535)), need_realign, -1);
                need_realign = 1'b0;
            end else if (pick < 94) begin
                send_long_varint(need_realign, $urandom_range(0, 4));
                need_realign = 1'b1;
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
                need_realign = 1'b1;
            end
        end
    endtask

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("mqtt_publish_payload_extractor_core test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_payloads();
        test_empty_commands();
        test_malformed_packets();
        test_buffer_realign();
        test_slot_overflow();
        test_random_traffic(360);
        drain_results();

        sender_idle_pct    = 70;
        receiver_stall_pct = 38;
        test_random_traffic(360);
        drain_results();

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_traffic(360);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (predicted_cmds.size() != 0) begin
            report_error($sformatf("%0d expected requests never arrived",
                                   predicted_cmds.size()));
        end
        $display("Sent %0d bytes in %0d packets, %s", bytes_sent, packets_sent,
                 "including empty, malformed, cut and oversized ones.");
        $display("Checked %0d payload, %0d empty, %0d malformed and %0d truncated requests.",
                 status_seen[mppe_pkg::ST_BYTE], status_seen[mppe_pkg::ST_EMPTY],
                 status_seen[mppe_pkg::ST_MALFORMED], status_seen[mppe_pkg::ST_TRUNC]);
        if (error_count == 0) begin
            $display("mqtt_publish_payload_extractor_core test passed");
        end else begin
            $display("mqtt_publish_payload_extractor_core test failed");
        end
        $finish;
    end

endmodule
